// File: hw/rtl/pulse_pair_parity_deframer_defines.svh
// Assertion macros for the pulse pair parity deframer.
`ifndef PULSE_PAIR_PARITY_DEFRAMER_DEFINES_SVH
`define PULSE_PAIR_PARITY_DEFRAMER_DEFINES_SVH

`ifndef SYNTH
`define PPD_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PPD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PPD_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons)
`define PPD_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons)
`endif

`endif

// File: hw/rtl/ppd_pkg.sv
// Shared types and constants of the pulse pair parity deframer.
`timescale 1ns / 1ps
package ppd_pkg;

  localparam logic [7:0] HIGH_OFFSET_RST = 8'd3;
  localparam logic [7:0] LOW_OFFSET_RST  = 8'd1;
  localparam logic [2:0] PAIRS_PER_BYTE  = 3'd4;
  localparam logic [7:0] SYM_PAR_EVEN    = 8'd2;
  localparam logic [7:0] SYM_PAR_ODD     = 8'd3;
  localparam logic [7:0] SYM_DATA_LIMIT  = 8'd2;
  localparam logic [7:0] BYTE_COUNT_MAX  = 8'hFF;

  localparam int unsigned CFG_AW = 3;
  localparam logic REG_HIGH_OFFSET = 1'b0;
  localparam logic REG_LOW_OFFSET  = 1'b1;

  typedef struct packed {
    logic [14:0] high_ticks;
    logic [14:0] low_ticks;
    logic        last_item;
  } ppd_in_t;

  typedef struct packed {
    logic       byte_ready;
    logic [7:0] data_byte;
    logic       corrupt_item;
    logic       any_error;
    logic [7:0] byte_count;
  } ppd_out_t;

  typedef struct packed {
    logic [7:0] shift_byte;
    logic [2:0] pair_index;
    logic       ones_parity;
    logic       error_seen;
    logic [7:0] bytes_done;
  } ppd_state_t;

endpackage

// File: hw/rtl/ppd_step.sv
// Per-item symbol decode and deframer state update.
`timescale 1ns / 1ps
module ppd_step import ppd_pkg::*; (
  input  ppd_in_t    item,
  input  logic [7:0] high_offset,
  input  logic [7:0] low_offset,
  input  ppd_state_t st,
  output ppd_state_t st_nxt,
  output ppd_out_t   res
);

  logic [7:0] v0;
  logic [7:0] v1_raw;
  logic [7:0] v1;
  logic       parity_ok;
  logic       data_ok;
  ppd_state_t upd;

  assign v0     = item.high_ticks[7:0] - high_offset;
  assign v1_raw = item.low_ticks[7:0];
  assign v1     = (v1_raw != 8'd0) ? (v1_raw - low_offset) : 8'd0;

  assign parity_ok = ((v0 == SYM_PAR_EVEN) || (v0 == SYM_PAR_ODD)) && (v1 == 8'd0) &&
                     (st.pair_index == PAIRS_PER_BYTE) && (v0[0] == st.ones_parity);
  assign data_ok   = (v0 < SYM_DATA_LIMIT) && (v1 < SYM_DATA_LIMIT) &&
                     (st.pair_index < PAIRS_PER_BYTE);

  always_comb begin
    upd = st;
    res = '0;
    priority if (parity_ok) begin
      res.byte_ready  = 1'b1;
      res.data_byte   = st.shift_byte;
      if (st.bytes_done != BYTE_COUNT_MAX) begin
        upd.bytes_done = st.bytes_done + 8'd1;
      end
      upd.shift_byte  = '0;
      upd.pair_index  = '0;
      upd.ones_parity = 1'b0;
    end else if (data_ok) begin
      upd.shift_byte  = {st.shift_byte[5:0], v0[0], v1[0]};
      upd.ones_parity = st.ones_parity ^ v0[0] ^ v1[0];
      upd.pair_index  = st.pair_index + 3'd1;
    end else begin
      res.corrupt_item = 1'b1;
      upd.shift_byte   = '0;
      upd.pair_index   = '0;
      upd.ones_parity  = 1'b0;
      upd.error_seen   = 1'b1;
    end
    res.any_error  = upd.error_seen;
    res.byte_count = upd.bytes_done;
    st_nxt = item.last_item ? '0 : upd;
  end

endmodule

// File: hw/rtl/pulse_pair_parity_deframer.sv
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while out_ready is high; a full result register is refilled in the cycle it is taken.
// Decode and state update sit between the input register and the result register.
// Reset (rst_n low, synchronous) empties both stages, clears decode state and
// sets high_offset to 3 and low_offset to 1.
`timescale 1ns / 1ps
module pulse_pair_parity_deframer import ppd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ppd_in_t           in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ppd_out_t          out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "pulse_pair_parity_deframer_defines.svh"

  logic [7:0] high_offset_r, high_offset_nxt;
  logic [7:0] low_offset_r, low_offset_nxt;
  logic       cfg_wr;

  logic       s1_valid_r, s1_valid_nxt;
  ppd_in_t    s1_data_r;
  logic       s1_fire;
  logic       adv;

  ppd_state_t st_r, st_nxt, st_upd;
  ppd_out_t   res;
  logic       out_valid_r, out_valid_nxt;
  ppd_out_t   out_data_r;

  // config port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    high_offset_nxt = high_offset_r;
    low_offset_nxt  = low_offset_r;
    if (cfg_wr) begin
      unique case (paddr[2])
        REG_HIGH_OFFSET: high_offset_nxt = pwdata[7:0];
        REG_LOW_OFFSET:  low_offset_nxt  = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_HIGH_OFFSET: prdata = {24'd0, high_offset_r};
      REG_LOW_OFFSET:  prdata = {24'd0, low_offset_r};
      default:         prdata = '0;
    endcase
  end

  // pipeline control
  assign adv      = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && adv;
  assign in_ready = !s1_valid_r || adv;

  assign s1_valid_nxt  = (in_valid && in_ready) ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  ppd_step u_step (
    .item        (s1_data_r),
    .high_offset (high_offset_r),
    .low_offset  (low_offset_r),
    .st          (st_r),
    .st_nxt      (st_upd),
    .res         (res)
  );

  assign st_nxt = s1_fire ? st_upd : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_offset_r <= HIGH_OFFSET_RST;
      low_offset_r  <= LOW_OFFSET_RST;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      st_r          <= '0;
    end else begin
      high_offset_r <= high_offset_nxt;
      low_offset_r  <= low_offset_nxt;
      s1_valid_r    <= s1_valid_nxt;
      out_valid_r   <= out_valid_nxt;
      st_r          <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PPD_ASSERT_IMP(a_pair_range, clk, rst_n, 1'b1, st_r.pair_index <= PAIRS_PER_BYTE)
  `PPD_ASSERT_IMP(a_corrupt_sticky, clk, rst_n, out_valid_r && out_data_r.corrupt_item,
                  out_data_r.any_error && !out_data_r.byte_ready)
  `PPD_ASSERT_NXT(a_last_clears, clk, rst_n, s1_fire && s1_data_r.last_item, st_r == '0)
  `PPD_ASSERT_IMP(a_empty_takes, clk, rst_n, !out_valid_r, in_ready)

endmodule
